/* rtl/blr_pkg.sv */
package blr_pkg;

  // command codes
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // step direction codes, read as a 2-bit signed value
  localparam logic [1:0] STEP_ZERO = 2'b00;
  localparam logic [1:0] STEP_POS  = 2'b01;
  localparam logic [1:0] STEP_NEG  = 2'b11;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // classification of one queued beat
  typedef struct packed {
    logic       is_start;
    logic       x_major;
    logic [1:0] step_x;
    logic [1:0] step_y;
  } blr_ctl_t;

endpackage

/* rtl/bresenham_line_rasterizer_top.sv */
// channel   | ports                                     | handshake
// ----------+-------------------------------------------+-------------------------
// command   | in_command, in_x/y_start, in_x/y_end      | push / full
// pixel     | out_pixel_x/y, out_pixel_valid/_last      | empty / pop
//
// one pixel per cycle sustained while pop drains the output; each command beat gives
// exactly one pixel beat; a push goes through setup into a 4-beat queue, then the
// stepper (one add and one sign test per step) into the output register
// synchronous active-low reset empties queue and output and drops any line
// a stalled output holds the stepper; the queue keeps taking beats until full
module bresenham_line_rasterizer_top
  import blr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_command,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_pixel_valid,
  output logic                  out_pixel_last
);

  logic                  hd_valid, hd_pop;
  blr_ctl_t              hd_ctl;
  logic [COORD_BITS-1:0] hd_x, hd_y, hd_major;
  logic [COORD_BITS+1:0] hd_err, hd_inc_d, hd_inc_s;

  // setup and command queue
  blr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_command (in_command),
    .in_x_start (in_x_start),
    .in_y_start (in_y_start),
    .in_x_end   (in_x_end),
    .in_y_end   (in_y_end),
    .hd_valid   (hd_valid),
    .hd_pop     (hd_pop),
    .hd_ctl     (hd_ctl),
    .hd_x       (hd_x),
    .hd_y       (hd_y),
    .hd_major   (hd_major),
    .hd_err     (hd_err),
    .hd_inc_d   (hd_inc_d),
    .hd_inc_s   (hd_inc_s)
  );

  // line stepper and output register
  blr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .hd_valid        (hd_valid),
    .hd_pop          (hd_pop),
    .hd_ctl          (hd_ctl),
    .hd_x            (hd_x),
    .hd_y            (hd_y),
    .hd_major        (hd_major),
    .hd_err          (hd_err),
    .hd_inc_d        (hd_inc_d),
    .hd_inc_s        (hd_inc_s),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_valid (out_pixel_valid),
    .out_pixel_last  (out_pixel_last)
  );

endmodule

/* rtl/blr_front.sv */
module blr_front
  import blr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_command,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  output logic                  hd_valid,
  input  logic                  hd_pop,
  output blr_ctl_t              hd_ctl,
  output logic [COORD_BITS-1:0] hd_x,
  output logic [COORD_BITS-1:0] hd_y,
  output logic [COORD_BITS-1:0] hd_major,
  output logic [COORD_BITS+1:0] hd_err,
  output logic [COORD_BITS+1:0] hd_inc_d,
  output logic [COORD_BITS+1:0] hd_inc_s
);

  localparam int EW = COORD_BITS + 2;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  typedef struct packed {
    blr_ctl_t              ctl;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] major;
    logic [EW-1:0]         err;
    logic [EW-1:0]         inc_d;
    logic [EW-1:0]         inc_s;
  } entry_t;

  entry_t          q_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  logic                  x_ge, y_ge;
  logic [COORD_BITS-1:0] dx, dy, major, minor;
  logic                  x_major;
  logic [EW-1:0]         two_minor;
  entry_t                entry;
  logic                  wr_en, rd_en;

  // setup: absolute deltas, directions, major axis, error terms
  always_comb begin
    x_ge    = (in_x_start >= in_x_end);
    y_ge    = (in_y_start >= in_y_end);
    dx      = x_ge ? (in_x_start - in_x_end) : (in_x_end - in_x_start);
    dy      = y_ge ? (in_y_start - in_y_end) : (in_y_end - in_y_start);
    x_major = (dx >= dy);
    major   = x_major ? dx : dy;
    minor   = x_major ? dy : dx;
    two_minor = {1'b0, minor, 1'b0};

    entry.ctl.is_start = (in_command == CMD_START);
    entry.ctl.x_major  = x_major;
    entry.ctl.step_x   = (in_x_start == in_x_end) ? STEP_ZERO : (x_ge ? STEP_NEG : STEP_POS);
    entry.ctl.step_y   = (in_y_start == in_y_end) ? STEP_ZERO : (y_ge ? STEP_NEG : STEP_POS);
    entry.x     = in_x_start;
    entry.y     = in_y_start;
    entry.major = major;
    entry.err   = two_minor - {2'b00, major};
    entry.inc_d = two_minor - {1'b0, major, 1'b0};
    entry.inc_s = two_minor;
  end

  // queue pointers and fill count
  assign full     = (count_r == FULL_COUNT);
  assign hd_valid = (count_r != '0);
  assign wr_en    = push && !full;
  assign rd_en    = hd_pop && hd_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (rd_en && !wr_en) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

  // head of queue
  assign hd_ctl   = q_r[rd_ptr_r].ctl;
  assign hd_x     = q_r[rd_ptr_r].x;
  assign hd_y     = q_r[rd_ptr_r].y;
  assign hd_major = q_r[rd_ptr_r].major;
  assign hd_err   = q_r[rd_ptr_r].err;
  assign hd_inc_d = q_r[rd_ptr_r].inc_d;
  assign hd_inc_s = q_r[rd_ptr_r].inc_s;

endmodule

/* rtl/blr_back.sv */
module blr_back
  import blr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  hd_valid,
  output logic                  hd_pop,
  input  blr_ctl_t              hd_ctl,
  input  logic [COORD_BITS-1:0] hd_x,
  input  logic [COORD_BITS-1:0] hd_y,
  input  logic [COORD_BITS-1:0] hd_major,
  input  logic [COORD_BITS+1:0] hd_err,
  input  logic [COORD_BITS+1:0] hd_inc_d,
  input  logic [COORD_BITS+1:0] hd_inc_s,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_pixel_valid,
  output logic                  out_pixel_last
);

  localparam int EW = COORD_BITS + 2;

  // line state
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic [EW-1:0]         err_r, err_nxt;
  logic [EW-1:0]         inc_d_r, inc_d_nxt;
  logic [EW-1:0]         inc_s_r, inc_s_nxt;
  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  blr_ctl_t              ctl_r, ctl_nxt;
  logic                  active_r, active_nxt;

  // output register
  logic                  ovalid_r, ovalid_nxt;
  logic [COORD_BITS-1:0] ox_r, ox_nxt;
  logic [COORD_BITS-1:0] oy_r, oy_nxt;
  logic                  opv_r, opv_nxt;
  logic                  olast_r, olast_nxt;

  logic                  go, diag;
  logic [COORD_BITS-1:0] step_x_ext, step_y_ext, mv_x, mv_y, rem_dec;

  // take a beat when the output slot is free or being drained
  assign go     = hd_valid && (!ovalid_r || pop);
  assign hd_pop = go;

  assign step_x_ext = {{(COORD_BITS-2){ctl_r.step_x[1]}}, ctl_r.step_x};
  assign step_y_ext = {{(COORD_BITS-2){ctl_r.step_y[1]}}, ctl_r.step_y};
  assign mv_x       = cur_x_r + step_x_ext;
  assign mv_y       = cur_y_r + step_y_ext;
  assign rem_dec    = rem_r - 1'b1;
  assign diag       = !err_r[EW-1];

  // per-beat execution
  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    err_nxt    = err_r;
    inc_d_nxt  = inc_d_r;
    inc_s_nxt  = inc_s_r;
    rem_nxt    = rem_r;
    ctl_nxt    = ctl_r;
    active_nxt = active_r;
    ovalid_nxt = ovalid_r && !pop;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    opv_nxt    = opv_r;
    olast_nxt  = olast_r;
    if (go) begin
      ovalid_nxt = 1'b1;
      if (hd_ctl.is_start) begin
        // load a new line and give its first pixel
        cur_x_nxt  = hd_x;
        cur_y_nxt  = hd_y;
        err_nxt    = hd_err;
        inc_d_nxt  = hd_inc_d;
        inc_s_nxt  = hd_inc_s;
        rem_nxt    = hd_major;
        ctl_nxt    = hd_ctl;
        active_nxt = (hd_major != '0);
        ox_nxt     = hd_x;
        oy_nxt     = hd_y;
        opv_nxt    = 1'b1;
        olast_nxt  = (hd_major == '0);
      end else if (!active_r) begin
        // advance with no line: empty pixel
        ox_nxt    = '0;
        oy_nxt    = '0;
        opv_nxt   = 1'b0;
        olast_nxt = 1'b0;
      end else begin
        // one step along the major axis, minor axis when error not negative
        cur_x_nxt  = (diag || ctl_r.x_major) ? mv_x : cur_x_r;
        cur_y_nxt  = (diag || !ctl_r.x_major) ? mv_y : cur_y_r;
        err_nxt    = err_r + (diag ? inc_d_r : inc_s_r);
        rem_nxt    = rem_dec;
        active_nxt = (rem_dec != '0);
        ox_nxt     = cur_x_nxt;
        oy_nxt     = cur_y_nxt;
        opv_nxt    = 1'b1;
        olast_nxt  = (rem_dec == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      err_r    <= '0;
      inc_d_r  <= '0;
      inc_s_r  <= '0;
      rem_r    <= '0;
      ctl_r    <= '0;
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      err_r    <= err_nxt;
      inc_d_r  <= inc_d_nxt;
      inc_s_r  <= inc_s_nxt;
      rem_r    <= rem_nxt;
      ctl_r    <= ctl_nxt;
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    opv_r   <= opv_nxt;
    olast_r <= olast_nxt;
  end

  assign empty           = !ovalid_r;
  assign out_pixel_x     = ox_r;
  assign out_pixel_y     = oy_r;
  assign out_pixel_valid = opv_r;
  assign out_pixel_last  = olast_r;

endmodule
